FILE: design/lba_pkg.sv
// ----------------------------------------------------------------------------
// lba_pkg
// Shared constants for the linked block allocator: default sizes, request
// opcodes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lba_pkg;

    // Default geometry of the block store and the file table.
    localparam int DISK_BLKS_DEF  = 32;
    localparam int NUM_FILES_DEF  = 8;

    // Request opcodes.
    localparam int OPCODE_W = 1;
    localparam logic [OPCODE_W-1:0] OP_CREATE = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_WALK   = 1'b1;

    // Result status codes.
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_REQ  = 2'd3;

endpackage

`default_nettype wire

FILE: design/lba_if.sv
// ----------------------------------------------------------------------------
// lba_req_if / lba_rsp_if
// Valid/ready channels of the allocator: the request channel carries create
// and walk requests, the response channel carries one block result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: opcode, block count for a create, file slot for a walk.
interface lba_req_if import lba_pkg::*; #(
    parameter int CNT_W  = $clog2(DISK_BLKS_DEF + 1),
    parameter int SLOT_W = $clog2(NUM_FILES_DEF)
) ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [CNT_W-1:0]    block_count;
    logic [SLOT_W-1:0]   file_slot;

    modport source (output valid, output opcode, output block_count, output file_slot,
                    input ready);
    modport sink   (input valid, input opcode, input block_count, input file_slot,
                    output ready);
endinterface

// Response channel: block number, last flag, file slot and status.
interface lba_rsp_if import lba_pkg::*; #(
    parameter int BLK_W  = $clog2(DISK_BLKS_DEF),
    parameter int SLOT_W = $clog2(NUM_FILES_DEF)
) ();
    logic                valid;
    logic                ready;
    logic [BLK_W-1:0]    block_index;
    logic                last;
    logic [SLOT_W-1:0]   file_slot_out;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output block_index, output last, output file_slot_out,
                    output status, input ready);
    modport sink   (input valid, input block_index, input last, input file_slot_out,
                    input status, output ready);
endinterface

`default_nettype wire

FILE: design/lba_out_stage.sv
// ----------------------------------------------------------------------------
// lba_out_stage
// Output register of the allocator. Holds one result until the consumer
// takes it and tells the sequencer when a new result may be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module lba_out_stage import lba_pkg::*; #(
    parameter int BLK_W  = $clog2(DISK_BLKS_DEF),
    parameter int SLOT_W = $clog2(NUM_FILES_DEF)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire logic [BLK_W-1:0]    i_block_index,
    input  wire logic                i_last,
    input  wire logic [SLOT_W-1:0]   i_file_slot,
    input  wire logic [STATUS_W-1:0] i_status,
    output logic                     o_free,
    lba_rsp_if.source                o_rsp
);

    logic                r_valid;
    logic [BLK_W-1:0]    r_block_index;
    logic                r_last;
    logic [SLOT_W-1:0]   r_file_slot;
    logic [STATUS_W-1:0] r_status;

    // The register can take a new result when empty or being drained now.
    assign o_free = !r_valid || o_rsp.ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_block_index <= i_block_index;
            r_last        <= i_last;
            r_file_slot   <= i_file_slot;
            r_status      <= i_status;
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.block_index   = r_block_index;
    assign o_rsp.last          = r_last;
    assign o_rsp.file_slot_out = r_file_slot;
    assign o_rsp.status        = r_status;

endmodule

`default_nettype wire

FILE: design/linked_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// linked_block_allocator_unit
// Linked block allocator: hands out the lowest free blocks to a new file,
// chains them in a link memory and reads a file's chain back on request.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake    Payload
//  i_req    in   valid/ready  opcode, block_count, file_slot
//  o_rsp    out  valid/ready  block_index, last, file_slot_out, status
//
// A request is taken only while the sequencer is idle. A create of n blocks
// gives one result per cycle while the output register is free; a walk reads
// the file table entry, then alternates emitting a block and reading its
// registered link. A refused request gives one error result. Blocks are never
// freed, so the used blocks are always the lowest ones and the free count
// serves as the fill mark: reset is synchronous and needs no clearing pass.
// A stalled consumer holds the sequencer at the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_block_allocator_unit import lba_pkg::*; #(
    parameter int DISK_BLKS  = DISK_BLKS_DEF,
    parameter int NUM_FILES  = NUM_FILES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lba_req_if.sink   i_req,
    lba_rsp_if.source o_rsp
);

    localparam int BLK_W  = $clog2(DISK_BLKS);
    localparam int CNT_W  = $clog2(DISK_BLKS + 1);
    localparam int SLOT_W = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
    localparam int FIU_W  = $clog2(NUM_FILES + 1);
    localparam int LINK_W = BLK_W + 1;
    localparam int FTAB_W = BLK_W + CNT_W;

    localparam logic [CNT_W-1:0]  DISK_BLKS_C  = CNT_W'(DISK_BLKS);
    localparam logic [FIU_W-1:0]  NUM_FILES_C  = FIU_W'(NUM_FILES);
    localparam logic [LINK_W-1:0] LINK_END     = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_CREATE,
        S_WALK_HDR,
        S_WALK_OUT,
        S_WALK_LINK
    } t_state;

    // Sequencer registers.
    t_state              r_state,          n_state;
    logic [BLK_W-1:0]    r_blk,            n_blk;
    logic [CNT_W-1:0]    r_remain,         n_remain;
    logic [SLOT_W-1:0]   r_slot,           n_slot;
    logic [STATUS_W-1:0] r_status,         n_status;
    logic [CNT_W-1:0]    r_free_count,     n_free_count;
    logic [FIU_W-1:0]    r_files_in_use,   n_files_in_use;

    // Memories and their registered read data.
    logic [LINK_W-1:0]   r_link_mem [DISK_BLKS];
    logic [FTAB_W-1:0]   r_ftab_mem [NUM_FILES];
    logic [LINK_W-1:0]   r_link_q;
    logic [FTAB_W-1:0]   r_ftab_q;

    logic                accept;
    logic                out_free;
    logic                ld;
    logic [BLK_W-1:0]    ld_blk;
    logic                ld_last;
    logic [SLOT_W-1:0]   ld_slot;
    logic [STATUS_W-1:0] ld_status;
    logic                is_last;
    logic                link_we;
    logic [LINK_W-1:0]   link_wdata;
    logic                ftab_we;
    logic [CNT_W-1:0]    used_count;
    logic [BLK_W-1:0]    alloc_base;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign is_last     = (r_remain == CNT_W'(1));

    // Blocks are taken from the bottom, so the next free block is the used count.
    assign used_count  = DISK_BLKS_C - r_free_count;
    assign alloc_base  = used_count[BLK_W-1:0];
    assign link_wdata  = is_last ? LINK_END : (LINK_W'(r_blk) + LINK_W'(1));

    // Next-state and result selection.
    always_comb begin
        n_state        = r_state;
        n_blk          = r_blk;
        n_remain       = r_remain;
        n_slot         = r_slot;
        n_status       = r_status;
        n_free_count   = r_free_count;
        n_files_in_use = r_files_in_use;
        ld             = 1'b0;
        ld_blk         = r_blk;
        ld_last        = is_last;
        ld_slot        = r_slot;
        ld_status      = ST_OK;
        link_we        = 1'b0;
        ftab_we        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.opcode == OP_CREATE) begin
                        n_slot = '0;
                        if (r_files_in_use >= NUM_FILES_C) begin
                            n_status = ST_FULL;
                            n_state  = S_ERR;
                        end else if (i_req.block_count == '0) begin
                            n_status = ST_BAD_REQ;
                            n_state  = S_ERR;
                        end else if (i_req.block_count > r_free_count) begin
                            n_status = ST_NO_SPACE;
                            n_state  = S_ERR;
                        end else begin
                            // The request will complete, so commit the counts now.
                            n_blk          = alloc_base;
                            n_remain       = i_req.block_count;
                            n_slot         = r_files_in_use[SLOT_W-1:0];
                            n_free_count   = r_free_count - i_req.block_count;
                            n_files_in_use = r_files_in_use + FIU_W'(1);
                            ftab_we        = 1'b1;
                            n_state        = S_CREATE;
                        end
                    end else begin
                        n_slot = i_req.file_slot;
                        if (FIU_W'(i_req.file_slot) >= r_files_in_use) begin
                            n_status = ST_BAD_REQ;
                            n_state  = S_ERR;
                        end else begin
                            n_state = S_WALK_HDR;
                        end
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    ld        = 1'b1;
                    ld_blk    = '0;
                    ld_last   = 1'b1;
                    ld_status = r_status;
                    n_state   = S_IDLE;
                end
            end
            S_CREATE: begin
                if (out_free) begin
                    ld       = 1'b1;
                    link_we  = 1'b1;
                    n_blk    = r_blk + BLK_W'(1);
                    n_remain = r_remain - CNT_W'(1);
                    if (is_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_WALK_HDR: begin
                n_blk    = r_ftab_q[FTAB_W-1:CNT_W];
                n_remain = r_ftab_q[CNT_W-1:0];
                n_state  = S_WALK_OUT;
            end
            S_WALK_OUT: begin
                if (out_free) begin
                    ld       = 1'b1;
                    n_remain = r_remain - CNT_W'(1);
                    n_state  = is_last ? S_IDLE : S_WALK_LINK;
                end
            end
            S_WALK_LINK: begin
                n_blk   = r_link_q[BLK_W-1:0];
                n_state = S_WALK_OUT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_free_count   <= DISK_BLKS_C;
            r_files_in_use <= '0;
        end else begin
            r_state        <= n_state;
            r_free_count   <= n_free_count;
            r_files_in_use <= n_files_in_use;
        end
        r_blk    <= n_blk;
        r_remain <= n_remain;
        r_slot   <= n_slot;
        r_status <= n_status;
    end

    // Link memory: written while a create emits, read at the current block.
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[r_blk] <= link_wdata;
        end
        r_link_q <= r_link_mem[r_blk];
    end

    // File table: start block and length, written on a create, read by slot.
    always_ff @(posedge i_clk) begin
        if (ftab_we) begin
            r_ftab_mem[r_files_in_use[SLOT_W-1:0]] <= {alloc_base, i_req.block_count};
        end
        r_ftab_q <= r_ftab_mem[i_req.file_slot];
    end

    // Output register.
    lba_out_stage #(
        .BLK_W  (BLK_W),
        .SLOT_W (SLOT_W)
    ) u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (ld),
        .i_block_index (ld_blk),
        .i_last        (ld_last),
        .i_file_slot   (ld_slot),
        .i_status      (ld_status),
        .o_free        (out_free),
        .o_rsp         (o_rsp)
    );

    // Counts stay within the store and table sizes.
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_count <= DISK_BLKS_C) && (r_files_in_use <= NUM_FILES_C))
        else $error("allocator counts out of range");

    // A result is loaded only when the output register can take it.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld |-> out_free)
        else $error("result loaded into a busy output register");

    // A chain being emitted always has blocks left.
    a_remain_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CREATE || r_state == S_WALK_OUT) |-> (r_remain != '0))
        else $error("chain emission with no blocks left");

    // A committed create takes exactly its blocks and one file slot.
    a_create_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && accept && ftab_we) |=>
            (r_free_count == $past(r_free_count) - $past(i_req.block_count)) &&
            (r_files_in_use == $past(r_files_in_use) + FIU_W'(1)))
        else $error("create committed wrong counts");

endmodule

`default_nettype wire
